// ===== sv/dncf_pkg.sv =====
// ----------------------------------------------------------------------------
// dncf_pkg
// Shared types and constants of the delimited numeric code framer.
// ----------------------------------------------------------------------------
package dncf_pkg;

    // Default longest code that the store holds.
    localparam int DNCF_MAX_LEN = 64;

    // Fixed byte values.
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_DIGIT_LO  = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_HI  = 8'h39;
    localparam logic [7:0] DELIM_RESET    = 8'h0D;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CHAR        = 2'd0,
        KIND_TOO_LONG    = 2'd1,
        KIND_NOT_NUMERIC = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_RUN,
        ST_DATA
    } state_t;

    // One result item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] code_char;
        logic       last;
    } result_t;

endpackage

// ===== sv/dncf_ram.sv =====
// ----------------------------------------------------------------------------
// dncf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dncf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dncf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dncf_ctrl
// Framing sequencer: stores code bytes into the RAM, judges the code on a
// terminator and replays it from the RAM into the output register.
// ----------------------------------------------------------------------------
module dncf_ctrl
    import dncf_pkg::*;
#(
    parameter int MAX_LEN = DNCF_MAX_LEN,
    parameter int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        delim,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic             digits_reg, digits_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    kind_t            pend_kind_reg, pend_kind_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;

    logic accept;
    logic is_term;
    logic is_digit;
    logic out_free;
    logic last_char;

    // Byte classification and slot status.
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign is_term   = (in_byte == delim) || (in_byte == BYTE_LF) || (in_byte == BYTE_CR);
    assign is_digit  = (in_byte >= BYTE_DIGIT_LO) && (in_byte <= BYTE_DIGIT_HI);
    assign out_free  = !out_valid_reg || out_ready;
    assign last_char = (idx_reg == (len_reg - CNT_W'(1)));

    // Next state, RAM access and result loading.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        digits_next    = digits_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pend_kind_next = pend_kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        in_ready       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[ADDR_W-1:0];
        wr_data        = in_byte;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && !is_term)
                begin
                    // Store the byte while room is left, else flag overflow.
                    if (fill_reg < CNT_W'(MAX_LEN))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                        if (!is_digit)
                        begin
                            digits_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (accept && (fill_reg != '0))
                begin
                    // Judge the code and reset the running state.
                    fill_next   = '0;
                    ovf_next    = 1'b0;
                    digits_next = 1'b1;
                    if (ovf_reg)
                    begin
                        pend_kind_next = KIND_TOO_LONG;
                        state_next     = ST_ERR;
                    end
                    else if (!digits_reg)
                    begin
                        pend_kind_next = KIND_NOT_NUMERIC;
                        state_next     = ST_ERR;
                    end
                    else
                    begin
                        len_next   = fill_reg;
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_ERR:
            begin
                // Single error result once the output register is free.
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_res_next.kind      = pend_kind_reg;
                    out_res_next.code_char = 8'h00;
                    out_res_next.last      = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            ST_RUN:
            begin
                // First read of the replay.
                rd_en      = 1'b1;
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                // Move the read byte out and fetch the next one behind it.
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_res_next.kind      = KIND_CHAR;
                    out_res_next.code_char = rd_data;
                    out_res_next.last      = last_char;
                    if (last_char)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_next[ADDR_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            digits_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            digits_reg    <= digits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        pend_kind_reg <= pend_kind_next;
        out_res_reg   <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== sv/delimited_numeric_code_framer.sv =====
// ----------------------------------------------------------------------------
// delimited_numeric_code_framer
// Collects scanner bytes into codes and emits numeric codes as characters,
// or a single error result for codes that are too long or not numeric.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: rx_byte
// m_axis    out        tdata: code_char, tuser: kind, tlast: last
// cfg       in         cfg_wdata: delimiter_byte, written on cfg_we
//
// Bytes are taken while idle. A terminator that yields an error holds off
// input until its result enters the output register; a numeric terminator
// holds off input through the first RAM read and the replay of every
// stored character, set by the single read port of the character RAM.
// Output stalls hold the replay in place. Reset clears the count and flags
// and sets the delimiter to CR; the character RAM is not cleared.
// ----------------------------------------------------------------------------
module delimited_numeric_code_framer
    import dncf_pkg::*;
#(
    parameter int MAX_LEN = DNCF_MAX_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] code_char
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [7:0]        delim_reg;
    result_t           res;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Delimiter register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_we)
        begin
            delim_reg <= cfg_wdata;
        end
    end

    // Sequencer.
    dncf_ctrl #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .delim     (delim_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Character store.
    dncf_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result fields onto the stream.
    assign m_axis_tdata = res.code_char;
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    // An error result always closes its code.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_CHAR)) |-> m_axis_tlast)
        else $error("error result without last");

    // An error result carries no character.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_CHAR)) |-> (m_axis_tdata == 8'h00))
        else $error("error result with nonzero character");

    // Replayed characters are decimal digits.
    a_char_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_CHAR)) |->
        ((m_axis_tdata >= BYTE_DIGIT_LO) && (m_axis_tdata <= BYTE_DIGIT_HI)))
        else $error("replayed character is not a digit");

endmodule
